/* rtl/gha_pkg.sv */
// Shared codes for the generational handle allocator.
// Request kinds on the input tuser and result status codes on the output tuser.
// No dependencies.
`default_nettype none

package gha_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

endpackage

`default_nettype wire

/* rtl/generational_handle_allocator_top.sv */
// Generational handle allocator: slot table and LIFO free stack in block memories.
// Depends on gha_pkg for request and status codes.
//
// Each request beat (allocate, free or check) yields exactly one result beat.
// A request passes IDLE, LOOK, EXEC: the accept cycle reads the free stack top,
// the next cycle reads the slot table at the chosen slot (the popped slot depends
// on the stack read), and EXEC, once the output register is empty or being
// taken, writes back and loads it. The next request is accepted in the cycle
// after that, even while the previous result still waits in the output register.
// Slots at or above the high-water mark read as dead with generation zero, so the
// slot table needs no clearing after reset; the block is ready right out of reset.
`default_nettype none

module generational_handle_allocator_top #(
    parameter int SLOT_COUNT = 64,
    parameter int GEN_BITS   = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output      logic                                   s_tready,
    // handle_index, handle_generation, zero pad
    input  wire logic [((($clog2(SLOT_COUNT) + GEN_BITS) + 7) / 8) * 8 - 1:0] s_tdata,
    // func
    input  wire logic [gha_pkg::FUNC_W-1:0]             s_tuser,
    output      logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    // out_index, out_generation, live_count, zero pad
    output      logic [((($clog2(SLOT_COUNT) + GEN_BITS + $clog2(SLOT_COUNT + 1)) + 7) / 8)
                       * 8 - 1:0]                       m_tdata,
    // status
    output      logic [gha_pkg::STATUS_W-1:0]           m_tuser
);

    localparam int IDX_W    = $clog2(SLOT_COUNT);
    localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int M_DATA_W = ((IDX_W + GEN_BITS + CNT_W + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef struct packed {
        logic                alive;
        logic [GEN_BITS-1:0] gen;
    } slot_t;

    slot_t            slot_mem [SLOT_COUNT];
    logic [IDX_W-1:0] stack_mem [SLOT_COUNT];

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]    used_slots_reg, used_slots_next;
    logic [CNT_W-1:0]    alive_total_reg, alive_total_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [gha_pkg::FUNC_W-1:0] func_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [GEN_BITS-1:0] gen_reg;
    logic                pop_reg;
    logic [IDX_W-1:0]    stack_rd_reg;
    logic [IDX_W-1:0]    target_reg;
    slot_t               slot_rd_reg;

    logic [gha_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [IDX_W-1:0]    m_index_reg, m_index_next;
    logic [GEN_BITS-1:0] m_gen_reg, m_gen_next;
    logic [CNT_W-1:0]    m_count_reg;

    logic                accept;
    logic                exec_fire;
    logic [CNT_W-1:0]    depth_m1;
    logic [IDX_W-1:0]    look_target;
    logic                entry_valid;
    logic                slot_alive;
    logic [GEN_BITS-1:0] slot_gen;
    logic                handle_ok;
    logic                alloc_got;
    logic                slot_we;
    slot_t               slot_wdata;
    logic                push_en;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign depth_m1  = free_depth_reg - CNT_ONE;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_DATA_W'({m_count_reg, m_gen_reg, m_index_reg});

    always_comb
    begin
        if (pop_reg)
        begin
            look_target = stack_rd_reg;
        end
        else if (func_reg == gha_pkg::FUNC_ALLOC)
        begin
            look_target = used_slots_reg[IDX_W-1:0];
        end
        else
        begin
            look_target = idx_reg;
        end
    end

    always_comb
    begin
        entry_valid = CNT_W'(target_reg) < used_slots_reg;
        slot_alive  = entry_valid && slot_rd_reg.alive;
        slot_gen    = entry_valid ? slot_rd_reg.gen : '0;
        handle_ok   = slot_alive && (slot_gen == gen_reg);
        alloc_got   = pop_reg || (used_slots_reg < CNT_MAX);

        free_depth_next  = free_depth_reg;
        used_slots_next  = used_slots_reg;
        alive_total_next = alive_total_reg;
        slot_we          = 1'b0;
        slot_wdata       = '{alive: 1'b0, gen: slot_gen};
        push_en          = 1'b0;
        m_status_next    = gha_pkg::STATUS_INVALID;
        m_index_next     = idx_reg;
        m_gen_next       = gen_reg;

        unique case (func_reg)
            gha_pkg::FUNC_ALLOC:
            begin
                if (alloc_got)
                begin
                    slot_we          = exec_fire;
                    slot_wdata       = '{alive: 1'b1, gen: slot_gen};
                    alive_total_next = alive_total_reg + CNT_ONE;
                    if (pop_reg)
                    begin
                        free_depth_next = depth_m1;
                    end
                    else
                    begin
                        used_slots_next = used_slots_reg + CNT_ONE;
                    end
                    m_status_next = gha_pkg::STATUS_OK;
                    m_index_next  = target_reg;
                    m_gen_next    = slot_gen;
                end
                else
                begin
                    m_status_next = gha_pkg::STATUS_FULL;
                end
            end
            gha_pkg::FUNC_FREE:
            begin
                if (handle_ok)
                begin
                    slot_we    = exec_fire;
                    slot_wdata = '{alive: 1'b0, gen: slot_gen + GEN_BITS'(1)};
                    if (alive_total_reg != '0)
                    begin
                        alive_total_next = alive_total_reg - CNT_ONE;
                    end
                    if (free_depth_reg < CNT_MAX)
                    begin
                        push_en         = exec_fire;
                        free_depth_next = free_depth_reg + CNT_ONE;
                    end
                    m_status_next = gha_pkg::STATUS_OK;
                end
            end
            gha_pkg::FUNC_CHECK:
            begin
                if (handle_ok)
                begin
                    m_status_next = gha_pkg::STATUS_OK;
                end
            end
            default:
            begin
                m_status_next = gha_pkg::STATUS_INVALID;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            free_depth_reg  <= '0;
            used_slots_reg  <= '0;
            alive_total_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (exec_fire)
            begin
                free_depth_reg  <= free_depth_next;
                used_slots_reg  <= used_slots_next;
                alive_total_reg <= alive_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser;
            idx_reg  <= s_tdata[IDX_W-1:0];
            gen_reg  <= s_tdata[IDX_W+GEN_BITS-1:IDX_W];
            pop_reg  <= (s_tuser == gha_pkg::FUNC_ALLOC) && (free_depth_reg != '0);
        end
        if (state_reg == ST_LOOK)
        begin
            target_reg <= look_target;
        end
        if (exec_fire)
        begin
            m_status_reg <= m_status_next;
            m_index_reg  <= m_index_next;
            m_gen_reg    <= m_gen_next;
            m_count_reg  <= alive_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stack_rd_reg <= stack_mem[depth_m1[IDX_W-1:0]];
        end
        if (push_en)
        begin
            stack_mem[free_depth_reg[IDX_W-1:0]] <= target_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            slot_rd_reg <= slot_mem[look_target];
        end
        if (slot_we)
        begin
            slot_mem[target_reg] <= slot_wdata;
        end
    end

    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(free_depth_reg) + (CNT_W + 1)'(alive_total_reg)
            == (CNT_W + 1)'(used_slots_reg))
        else $error("free plus alive slots differ from high-water mark");

    a_used_mono: assert property (@(posedge clk) disable iff (!rst_n)
        used_slots_reg >= $past(used_slots_reg))
        else $error("high-water mark decreased");

    a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
        used_slots_reg <= CNT_MAX)
        else $error("high-water mark beyond slot count");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("result beat raised outside write-back");

endmodule

`default_nettype wire

/* bench/tb_generational_handle_allocator_top.sv */
// Self-checking bench for generational_handle_allocator_top: directed table, then random
// allocate/free/check traffic scored against an in-bench slot map model. Bursty sender,
// patterned receiver with one long hold-off. Depends on gha_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_generational_handle_allocator_top;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = 6;
    localparam int GEN_W  = 16;
    localparam int LIVE_W = 7;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_START   = 600;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [gha_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [gha_pkg::FUNC_W-1:0] func;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
    } req_t;

    typedef struct {
        logic [gha_pkg::STATUS_W-1:0] status;
        logic [IDX_W-1:0]    idx;
        logic [GEN_W-1:0]    gen;
        logic [LIVE_W-1:0]   live;
    } rsp_t;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [gha_pkg::FUNC_W-1:0] s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [gha_pkg::STATUS_W-1:0] m_tuser;

    // slot map model
    bit               slot_alive [SLOTS];
    logic [GEN_W-1:0] slot_gen [SLOTS];
    logic [IDX_W-1:0] freed_slots [SLOTS];
    int               freed_depth;
    int               high_water;
    int               alive_count;

    rsp_t     pending_results[$];
    dir_row_t dir_rows[$];
    bit       typed_hold;
    rsp_t     typed_want;

    int error_count;
    int result_count;
    int alloc_ok_count, full_count, free_ok_count, check_ok_count, invalid_count;
    int peak_live;
    bit growing;

    generational_handle_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic bit handle_valid(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
        if (int'(idx) >= high_water)
            return 1'b0;
        return slot_alive[idx] && slot_gen[idx] == gen;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        int   slot;
        bit   got;
        o.status = gha_pkg::STATUS_INVALID;
        o.idx    = r.idx;
        o.gen    = r.gen;
        slot     = 0;
        got      = 1'b0;
        case (r.func)
            gha_pkg::FUNC_ALLOC:
            begin
                if (freed_depth > 0)
                begin
                    freed_depth--;
                    slot = int'(freed_slots[freed_depth]);
                    got  = 1'b1;
                end
                else if (high_water < SLOTS)
                begin
                    slot = high_water;
                    high_water++;
                    got = 1'b1;
                end
                if (got)
                begin
                    slot_alive[slot] = 1'b1;
                    alive_count++;
                    o.status = gha_pkg::STATUS_OK;
                    o.idx    = IDX_W'(slot);
                    o.gen    = slot_gen[slot];
                end
                else
                    o.status = gha_pkg::STATUS_FULL;
            end
            gha_pkg::FUNC_FREE:
            begin
                if (handle_valid(r.idx, r.gen))
                begin
                    slot_alive[r.idx] = 1'b0;
                    slot_gen[r.idx]   = slot_gen[r.idx] + GEN_W'(1);
                    if (alive_count > 0)
                        alive_count--;
                    // drop a push past the stack bound
                    if (freed_depth < SLOTS)
                    begin
                        freed_slots[freed_depth] = r.idx;
                        freed_depth++;
                    end
                    o.status = gha_pkg::STATUS_OK;
                end
            end
            gha_pkg::FUNC_CHECK:
                o.status = handle_valid(r.idx, r.gen) ? gha_pkg::STATUS_OK
                                                      : gha_pkg::STATUS_INVALID;
            default:
                o.status = gha_pkg::STATUS_INVALID;
        endcase
        o.live = LIVE_W'(alive_count);
        return o;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t ns: result %0d %s mismatch: got 0x%0h, expected 0x%0h",
                 $time, result_count, field, got, want);
        error_count++;
    endtask

    // score results and advance the model on every accepted beat
    always @(posedge clk)
    begin : scoreboard
        rsp_t got;
        rsp_t want;
        req_t r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.idx    = m_tdata[5:0];
                got.gen    = m_tdata[21:6];
                got.live   = m_tdata[28:22];
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing outstanding", $time);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.idx !== want.idx)
                        report_mismatch("out_index", int'(got.idx), int'(want.idx));
                    if (got.gen !== want.gen)
                        report_mismatch("out_generation", int'(got.gen), int'(want.gen));
                    if (got.live !== want.live)
                        report_mismatch("live_count", int'(got.live), int'(want.live));
                end
                result_count++;
            end
            if (s_tvalid && s_tready)
            begin
                r.func = s_tuser;
                r.idx  = s_tdata[5:0];
                r.gen  = s_tdata[21:6];
                want   = apply_request(r);
                case (want.status)
                    gha_pkg::STATUS_OK:
                    begin
                        if (r.func == gha_pkg::FUNC_ALLOC)
                            alloc_ok_count++;
                        else if (r.func == gha_pkg::FUNC_FREE)
                            free_ok_count++;
                        else
                            check_ok_count++;
                    end
                    gha_pkg::STATUS_FULL:
                        full_count++;
                    default:
                        invalid_count++;
                endcase
                if (alive_count > peak_live)
                    peak_live = alive_count;
                pending_results.insert(pending_results.size(),
                                       typed_hold ? typed_want : want);
            end
        end
    end

    task automatic add_row(logic [gha_pkg::FUNC_W-1:0] func, logic [IDX_W-1:0] idx,
                           logic [GEN_W-1:0] gen, bit typed,
                           logic [gha_pkg::STATUS_W-1:0] st, logic [IDX_W-1:0] oi,
                           logic [GEN_W-1:0] og, logic [LIVE_W-1:0] lc);
        dir_row_t row;
        row.req.func    = func;
        row.req.idx     = idx;
        row.req.gen     = gen;
        row.typed       = typed;
        row.want.status = st;
        row.want.idx    = oi;
        row.want.gen    = og;
        row.want.live   = lc;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    int burst_left;

    // offer one beat at the falling edge, hold until accepted
    task automatic drive_request(req_t r, bit typed, rsp_t want);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
        end
        burst_left--;
        s_tuser    = r.func;
        s_tdata    = {2'b00, r.gen, r.idx};
        typed_hold = typed;
        typed_want = want;
        s_tvalid   = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    function automatic int pick_alive();
        int start;
        int s;
        if (alive_count == 0)
            return -1;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            s = (start + k) % SLOTS;
            if (slot_alive[s])
                return s;
        end
        return -1;
    endfunction

    function automatic req_t build_random();
        req_t r;
        int   roll;
        int   alloc_w;
        int   s;
        r.func = gha_pkg::FUNC_ALLOC;
        r.idx  = IDX_W'($urandom_range(SLOTS - 1));
        r.gen  = GEN_W'($urandom_range(16'hFFFF));
        if (alive_count == SLOTS && $urandom_range(3) == 0)
            growing = 1'b0;
        if (alive_count == 0)
            growing = 1'b1;
        if ($urandom_range(199) == 0)
            growing = !growing;
        alloc_w = growing ? 50 : 15;
        roll    = $urandom_range(99);
        s       = pick_alive();
        if (roll < alloc_w)
            r.func = gha_pkg::FUNC_ALLOC;
        else if (roll < alloc_w + 25 && s >= 0)
        begin
            r.func = gha_pkg::FUNC_FREE;
            r.idx  = IDX_W'(s);
            r.gen  = slot_gen[s];
        end
        else if (roll < alloc_w + 37 && s >= 0)
        begin
            r.func = gha_pkg::FUNC_CHECK;
            r.idx  = IDX_W'(s);
            r.gen  = slot_gen[s];
        end
        else if (roll < alloc_w + 47 && high_water > 0)
        begin
            // stale, dead or live handles below the high-water mark
            r.func = $urandom_range(1) ? gha_pkg::FUNC_FREE : gha_pkg::FUNC_CHECK;
            r.idx  = IDX_W'($urandom_range(high_water - 1));
            r.gen  = slot_gen[r.idx];
            if ($urandom_range(1))
                r.gen = r.gen ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
        end
        else
            r.func = gha_pkg::FUNC_W'($urandom_range(3));
        return r;
    endfunction

    // receiver stall patterns, with one long hold-off
    initial
    begin : receiver
        int cyc;
        int mode;
        m_tready = 1'b0;
        cyc      = 0;
        mode     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(3);
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                m_tready = 1'b0;
            else
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(1));
                    2: m_tready = (cyc % 4) != 3;
                    default: m_tready = (cyc % 5) == 0;
                endcase
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : sender
        req_t r;
        rsp_t none;
        rsp_t want;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = gha_pkg::FUNC_ALLOC;
        typed_hold  = 1'b0;
        typed_want  = '{default: '0};
        none        = '{default: '0};
        rst_n       = 1'b0;
        error_count = 0;
        result_count   = 0;
        alloc_ok_count = 0;
        full_count     = 0;
        free_ok_count  = 0;
        check_ok_count = 0;
        invalid_count  = 0;
        peak_live   = 0;
        growing     = 1'b1;
        burst_left  = 0;
        freed_depth = 0;
        high_water  = 0;
        alive_count = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_alive[i]  = 1'b0;
            slot_gen[i]    = '0;
            freed_slots[i] = '0;
        end

        add_row(gha_pkg::FUNC_CHECK, 6'd0, 16'h0000, 1,
                gha_pkg::STATUS_INVALID, 6'd0, 16'h0000, 7'd0);
        add_row(gha_pkg::FUNC_FREE, 6'd63, 16'hFFFF, 1,
                gha_pkg::STATUS_INVALID, 6'd63, 16'hFFFF, 7'd0);
        add_row(FUNC_UNUSED, 6'd21, 16'hAAAA, 1,
                gha_pkg::STATUS_INVALID, 6'd21, 16'hAAAA, 7'd0);
        add_row(gha_pkg::FUNC_ALLOC, 6'd42, 16'h5555, 1,
                gha_pkg::STATUS_OK, 6'd0, 16'h0000, 7'd1);
        add_row(gha_pkg::FUNC_ALLOC, 6'd63, 16'hFFFF, 1,
                gha_pkg::STATUS_OK, 6'd1, 16'h0000, 7'd2);
        add_row(gha_pkg::FUNC_CHECK, 6'd0, 16'h0000, 1,
                gha_pkg::STATUS_OK, 6'd0, 16'h0000, 7'd2);
        add_row(gha_pkg::FUNC_CHECK, 6'd0, 16'h0001, 1,
                gha_pkg::STATUS_INVALID, 6'd0, 16'h0001, 7'd2);
        add_row(gha_pkg::FUNC_CHECK, 6'd1, 16'hFFFF, 1,
                gha_pkg::STATUS_INVALID, 6'd1, 16'hFFFF, 7'd2);
        add_row(gha_pkg::FUNC_FREE, 6'd0, 16'h0000, 1,
                gha_pkg::STATUS_OK, 6'd0, 16'h0000, 7'd1);
        add_row(gha_pkg::FUNC_CHECK, 6'd0, 16'h0000, 1,
                gha_pkg::STATUS_INVALID, 6'd0, 16'h0000, 7'd1);
        add_row(gha_pkg::FUNC_FREE, 6'd0, 16'h0000, 1,
                gha_pkg::STATUS_INVALID, 6'd0, 16'h0000, 7'd1);
        add_row(gha_pkg::FUNC_ALLOC, 6'd0, 16'h0000, 1,
                gha_pkg::STATUS_OK, 6'd0, 16'h0001, 7'd2);
        add_row(gha_pkg::FUNC_FREE, 6'd1, 16'h0000, 0, '0, '0, '0, '0);
        add_row(gha_pkg::FUNC_FREE, 6'd0, 16'h0001, 0, '0, '0, '0, '0);
        add_row(gha_pkg::FUNC_ALLOC, 6'd0, 16'h0000, 0, '0, '0, '0, '0);
        add_row(gha_pkg::FUNC_ALLOC, 6'd0, 16'h0000, 0, '0, '0, '0, '0);
        add_row(gha_pkg::FUNC_ALLOC, 6'd0, 16'h0000, 1,
                gha_pkg::STATUS_OK, 6'd2, 16'h0000, 7'd3);
        add_row(gha_pkg::FUNC_CHECK, 6'd2, 16'h0000, 1,
                gha_pkg::STATUS_OK, 6'd2, 16'h0000, 7'd3);
        add_row(gha_pkg::FUNC_CHECK, 6'd3, 16'h0000, 1,
                gha_pkg::STATUS_INVALID, 6'd3, 16'h0000, 7'd3);
        add_row(FUNC_UNUSED, 6'd63, 16'h0000, 1,
                gha_pkg::STATUS_INVALID, 6'd63, 16'h0000, 7'd3);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            drive_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // fill the table, then allocate into a full table
        r.idx = '0;
        r.gen = '0;
        r.func = gha_pkg::FUNC_ALLOC;
        while (alive_count < SLOTS)
            drive_request(r, 0, none);
        want.status = gha_pkg::STATUS_FULL;
        want.live   = LIVE_W'(SLOTS);
        r.idx = 6'd63;
        r.gen = 16'hFFFF;
        want.idx = r.idx;
        want.gen = r.gen;
        drive_request(r, 1, want);
        r.idx = 6'd0;
        r.gen = 16'h0000;
        want.idx = r.idx;
        want.gen = r.gen;
        drive_request(r, 1, want);
        growing = 1'b0;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = build_random();
            drive_request(r, 0, none);
        end
        s_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d results: %0d allocated, %0d full, %0d freed, %0d checks valid,",
                 result_count, alloc_ok_count, full_count, free_ok_count, check_ok_count);
        $display("%0d invalid requests, peak of %0d live handles", invalid_count, peak_live);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/gha_pkg.sv
rtl/generational_handle_allocator_top.sv
bench/tb_generational_handle_allocator_top.sv
